/* src/note_directory_page_allocator_core_macros.svh */
// assertion macros for the note directory allocator
`ifndef NOTE_DIRECTORY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define NOTE_DIRECTORY_PAGE_ALLOCATOR_CORE_MACROS_SVH
// property that must hold on every clock outside reset
`define NDPA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// implication checked from the next clock
`define NDPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* src/ndpa_pkg.sv */
// shared types and constants of the note directory allocator
package ndpa_pkg;
  localparam int DirEntries = 16;
  localparam int DataPages  = 123;
  localparam int PageBytes  = 256;
  localparam int SlotW      = $clog2(DirEntries);
  localparam int PageW      = $clog2(DataPages + 1);
  localparam int CountW     = $clog2(DirEntries + 1);
  localparam int PageShift  = $clog2(PageBytes);

  localparam logic [2:0] CmdAlloc  = 3'd0;
  localparam logic [2:0] CmdFind   = 3'd1;
  localparam logic [2:0] CmdDelete = 3'd2;
  localparam logic [2:0] CmdState  = 3'd3;
  localparam logic [2:0] CmdQuery  = 3'd4;
  localparam logic [2:0] CmdFormat = 3'd5;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoPack  = 3'd1;
  localparam logic [2:0] StInvalid = 3'd2;
  localparam logic [2:0] StExists  = 3'd3;
  localparam logic [2:0] StDirFull = 3'd4;
  localparam logic [2:0] StDataFul = 3'd5;

  // one directory entry
  typedef struct packed {
    logic        used;
    logic [31:0] game;
    logic [15:0] company;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [31:0] ext;
    logic [PageW-1:0] start;
    logic [PageW-1:0] pages;
  } entry_t;

  // summary gathered over one directory scan
  typedef struct packed {
    logic             match_found;
    logic [SlotW-1:0] match_slot;
    logic             free_found;
    logic [SlotW-1:0] free_slot;
    logic [PageW-1:0] total_pages;
    logic [PageW-1:0] end_page;
    logic [CountW-1:0] used_count;
  } scan_t;
endpackage

/* src/ndpa_scan.sv */
// sequential scan unit: one directory entry per cycle while step is high, accumulates lookup and sums
module ndpa_scan import ndpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             step,
  input  logic [SlotW-1:0] idx,
  input  entry_t           ent,
  input  logic [15:0]      maker_id,
  input  logic [31:0]      title_id,
  input  logic [63:0]      name_high,
  input  logic [63:0]      name_low,
  input  logic             name_given,
  input  logic [31:0]      ext,
  input  logic             ext_given,
  output scan_t            res
);
  scan_t res_r, res_nxt;
  logic hit;
  logic [PageW:0] endp;

  // compare of one entry against the key
  always_comb begin
    hit = ent.used && ent.company == maker_id && ent.game == title_id &&
          (!name_given || (ent.name_high == name_high && ent.name_low == name_low)) &&
          (!ext_given || ent.ext == ext);
    endp = {1'b0, ent.start} + {1'b0, ent.pages};
  end

  // accumulate
  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt = '0;
    end else if (step) begin
      if (hit && !res_r.match_found) begin
        res_nxt.match_found = 1'b1;
        res_nxt.match_slot  = idx;
      end
      if (!ent.used && !res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_slot  = idx;
      end
      if (ent.used) begin
        res_nxt.total_pages = res_r.total_pages + ent.pages;
        res_nxt.used_count  = res_r.used_count + 1'b1;
        if (endp[PageW-1:0] > res_r.end_page) res_nxt.end_page = endp[PageW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_r <= '0;
    else res_r <= res_nxt;
  end

  assign res = res_r;
endmodule

/* src/note_directory_page_allocator_core.sv */
// top level of the note directory with compacting page allocator
// channel | dir | handshake        | payload
// in_     | in  | in_valid/in_stall | cmd, codes, name, ext, size, slot
// out_    | out | out_valid/out_stall| status, slot, entry fields, totals
// cfg_    | in  | cfg_we            | pak_ready
// out_valid rises after a first directory scan, one entry per cycle in the shared
// scan unit, one decide state, then a second pass for write, compaction and final totals.
// reset clears every directory entry at once (entries are flops).
// out_valid holds until the beat leaves; in_stall is high while busy.
module note_directory_page_allocator_core import ndpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_pak_ready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_maker_id,
  input  logic [31:0] in_title_id,
  input  logic [63:0] in_name_high,
  input  logic [63:0] in_name_low,
  input  logic        in_name_given,
  input  logic [31:0] in_ext,
  input  logic        in_ext_given,
  input  logic [15:0] in_file_size,
  input  logic [3:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [14:0] out_file_bytes,
  output logic [31:0] out_title_id,
  output logic [15:0] out_maker_id,
  output logic [63:0] out_out_name_high,
  output logic [63:0] out_out_name_low,
  output logic [31:0] out_out_ext,
  output logic [14:0] out_free_bytes,
  output logic [4:0]  out_files_used
);
`include "note_directory_page_allocator_core_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN1 = 5'b00010,
    S_DEC   = 5'b00100,
    S_SCAN2 = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic pak_r;
  entry_t dir_r [DirEntries];
  logic [SlotW:0] idx_r, idx_nxt;
  // latched command
  logic [2:0]  cmd_r;
  logic [15:0] comp_r;
  logic [31:0] game_r, ext_r;
  logic [63:0] nh_r, nl_r;
  logic        ng_r, eg_r;
  logic [15:0] size_r;
  logic [3:0]  sidx_r;
  // result registers
  logic [2:0]  st_r;
  logic [3:0]  slot_r;
  logic [14:0] fb_r;
  entry_t      fe_r;
  // delete and allocate bookkeeping
  logic             del_r;
  logic [SlotW-1:0] tgt_r;
  logic [PageW-1:0] gap_r, dpages_r;
  logic             wr_r;
  logic [PageW-1:0] need_r, start_pg_r;
  // decide results
  logic [2:0]       st_nxt;
  logic [3:0]       slot_nxt;
  logic [14:0]      fb_nxt;
  entry_t           fe_nxt;
  logic             wr_nxt, del_nxt, fmt_clr;
  logic [SlotW-1:0] tgt_nxt;
  // second pass entry update
  entry_t new_ent, scan_ent;
  logic   ent_wr;

  scan_t  sres;
  logic   sc_start, sc_step;
  entry_t cur;
  logic [PageW:0] need_w;
  logic [PageW:0] tot_need;

  assign cur      = dir_r[idx_r[SlotW-1:0]];
  assign sc_start = (state_r == S_IDLE) || (state_r == S_DEC);
  assign sc_step  = (state_r == S_SCAN1 || state_r == S_SCAN2) && !idx_r[SlotW];
  assign need_w   = (size_r[15:PageShift] + (|size_r[PageShift-1:0] ? 1'b1 : 1'b0)) > DataPages
                  ? (PageW+1)'(DataPages + 1)
                  : (PageW+1)'(size_r[15:PageShift] + (|size_r[PageShift-1:0] ? 1'b1 : 1'b0));
  assign tot_need = {1'b0, sres.total_pages} + need_w;

  ndpa_scan u_scan (
    .clk, .rst_n, .start(sc_start), .step(sc_step), .idx(idx_r[SlotW-1:0]), .ent(scan_ent),
    .maker_id(comp_r), .title_id(game_r), .name_high(nh_r), .name_low(nl_r),
    .name_given(ng_r), .ext(ext_r), .ext_given(eg_r), .res(sres)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN1;
          idx_nxt   = '0;
        end
      end
      S_SCAN1: begin
        if (idx_r[SlotW]) state_nxt = S_DEC;
        else idx_nxt = idx_r + 1'b1;
      end
      S_DEC: begin
        state_nxt = S_SCAN2;
        idx_nxt   = '0;
      end
      S_SCAN2: begin
        if (idx_r[SlotW]) state_nxt = S_OUT;
        else idx_nxt = idx_r + 1'b1;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // decide on the first scan totals
  always_comb begin
    st_nxt   = StOk;
    slot_nxt = '0;
    fb_nxt   = '0;
    fe_nxt   = '0;
    wr_nxt   = 1'b0;
    del_nxt  = 1'b0;
    tgt_nxt  = '0;
    fmt_clr  = 1'b0;
    if (cmd_r > CmdFormat) st_nxt = StInvalid;
    else if (!pak_r) st_nxt = StNoPack;
    else begin
      case (cmd_r)
        CmdAlloc: begin
          if (size_r == '0) st_nxt = StInvalid;
          else if (sres.match_found) st_nxt = StExists;
          else if (!sres.free_found) st_nxt = StDirFull;
          else if (tot_need > DataPages) st_nxt = StDataFul;
          else begin
            wr_nxt   = 1'b1;
            tgt_nxt  = sres.free_slot;
            slot_nxt = 4'(sres.free_slot);
          end
        end
        CmdFind, CmdDelete: begin
          if (!sres.match_found) st_nxt = StInvalid;
          else begin
            slot_nxt = 4'(sres.match_slot);
            if (cmd_r == CmdDelete) begin
              del_nxt = 1'b1;
              tgt_nxt = sres.match_slot;
            end
          end
        end
        CmdState: begin
          if (!dir_r[sidx_r[SlotW-1:0]].used) st_nxt = StInvalid;
          else begin
            fe_nxt = dir_r[sidx_r[SlotW-1:0]];
            fb_nxt = 15'({dir_r[sidx_r[SlotW-1:0]].pages, {PageShift{1'b0}}});
          end
        end
        CmdFormat: fmt_clr = 1'b1;
        default: ;
      endcase
    end
  end

  // second pass: entry as it stands after this cycle, fed to the scan for totals
  always_comb begin
    new_ent = '{used: 1'b1, game: game_r, company: comp_r,
                name_high: ng_r ? nh_r : 64'd0, name_low: ng_r ? nl_r : 64'd0,
                ext: eg_r ? ext_r : 32'd0, start: start_pg_r, pages: need_r};
    scan_ent = cur;
    ent_wr   = 1'b0;
    if (state_r == S_SCAN2 && !idx_r[SlotW]) begin
      if ((del_r || wr_r) && idx_r[SlotW-1:0] == tgt_r) begin
        scan_ent = del_r ? '0 : new_ent;
        ent_wr   = 1'b1;
      end else if (del_r && cur.used && cur.start > gap_r) begin
        scan_ent.start = cur.start - dpages_r;
        ent_wr         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      pak_r   <= 1'b0;
      del_r   <= 1'b0;
      wr_r    <= 1'b0;
      for (int i = 0; i < DirEntries; i++) dir_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) pak_r <= cfg_pak_ready;
      // capture the command beat
      if (state_r == S_IDLE && in_valid) begin
        cmd_r <= in_cmd; comp_r <= in_maker_id; game_r <= in_title_id;
        nh_r <= in_name_high; nl_r <= in_name_low; ng_r <= in_name_given;
        ext_r <= in_ext; eg_r <= in_ext_given; size_r <= in_file_size;
        sidx_r <= in_slot_index;
        del_r <= 1'b0; wr_r <= 1'b0;
      end
      // register the decision
      if (state_r == S_DEC) begin
        st_r <= st_nxt; slot_r <= slot_nxt; fb_r <= fb_nxt; fe_r <= fe_nxt;
        wr_r <= wr_nxt; del_r <= del_nxt; tgt_r <= tgt_nxt;
        gap_r <= dir_r[sres.match_slot].start;
        dpages_r <= dir_r[sres.match_slot].pages;
        need_r <= need_w[PageW-1:0];
        start_pg_r <= sres.end_page;
      end
      // directory writes: format clear, or one entry per second-pass cycle
      if (state_r == S_DEC && fmt_clr) begin
        for (int i = 0; i < DirEntries; i++) dir_r[i] <= '0;
      end else if (ent_wr) begin
        dir_r[idx_r[SlotW-1:0]] <= scan_ent;
      end
    end
  end

  // outputs; second scan gives totals after the command
  logic ok_totals;
  logic [PageW-1:0] freep;
  logic [PageW:0] tot_fix;
  assign ok_totals = pak_r && cmd_r <= CmdFormat;
  assign tot_fix   = {1'b0, sres.total_pages};
  assign freep     = (tot_fix >= DataPages) ? '0 : PageW'(DataPages - tot_fix);
  assign out_valid = (state_r == S_OUT);
  assign in_stall  = (state_r != S_IDLE);
  assign out_status = st_r;
  assign out_slot   = slot_r;
  assign out_file_bytes    = fb_r;
  assign out_title_id      = fe_r.game;
  assign out_maker_id      = fe_r.company;
  assign out_out_name_high = fe_r.name_high;
  assign out_out_name_low  = fe_r.name_low;
  assign out_out_ext       = fe_r.ext;
  assign out_free_bytes = ok_totals ? 15'({freep, {PageShift{1'b0}}}) : '0;
  assign out_files_used = ok_totals ? 5'(sres.used_count) : '0;

  `NDPA_ASSERT_ALWAYS(a_stall_busy, clk, rst_n, (state_r == S_IDLE) == !in_stall,
    "stall must follow busy")
  `NDPA_ASSERT_NEXT(a_scan_end, clk, rst_n, state_r == S_SCAN2 && idx_r[SlotW],
    state_r == S_OUT, "second scan must end in output")
  `NDPA_ASSERT_ALWAYS(a_one_job, clk, rst_n, !(del_r && wr_r), "delete and allocate at once")
  `NDPA_ASSERT_ALWAYS(a_used_max, clk, rst_n, sres.used_count <= DirEntries, "count overflow")
endmodule
